### hdl/sar_pkg.sv
// Shared types, codes and decode functions for the serial ACIA register block.
// Depends on nothing; sar_regs, sar_resp and the top level import it.
package sar_pkg;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_RX_BYTE = 2'd2;
    localparam logic [1:0] OP_RESET   = 2'd3;

    localparam logic [3:0] OFF_DATA    = 4'd8;
    localparam logic [3:0] OFF_STATUS  = 4'd9;
    localparam logic [3:0] OFF_COMMAND = 4'd10;
    localparam logic [3:0] OFF_CONTROL = 4'd11;

    localparam logic [7:0] STATUS_BASE  = 8'h10;
    localparam logic [7:0] STATUS_RXFUL = 8'h08;
    localparam logic [7:0] STATUS_IRQ   = 8'h80;

    localparam logic [2:0] PARITY_NONE = 3'd0;
    localparam logic [2:0] PARITY_ODD  = 3'd1;

    localparam logic [1:0] STOP_ONE      = 2'd0;
    localparam logic [1:0] STOP_ONE_HALF = 2'd1;
    localparam logic [1:0] STOP_TWO      = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        bus_driven;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_level;
        logic        line_update;
        logic [14:0] baud_rate;
        logic [3:0]  data_bits;
        logic [2:0]  parity_mode;
        logic [1:0]  stop_mode;
    } out_item_t;

    // One transaction leaving the register stage; pop_hit marks that read_data
    // is taken from the receive store's registered read port instead.
    typedef struct packed {
        logic      valid;
        logic      pop_hit;
        out_item_t item;
    } stage_t;

    function automatic logic [14:0] baud_lookup(input logic [3:0] sel);
        logic [14:0] rate;
        unique case (sel)
            4'd0:  rate = 15'd0;
            4'd1:  rate = 15'd50;
            4'd2:  rate = 15'd75;
            4'd3:  rate = 15'd110;
            4'd4:  rate = 15'd135;
            4'd5:  rate = 15'd150;
            4'd6:  rate = 15'd300;
            4'd7:  rate = 15'd600;
            4'd8:  rate = 15'd1200;
            4'd9:  rate = 15'd1800;
            4'd10: rate = 15'd2400;
            4'd11: rate = 15'd3600;
            4'd12: rate = 15'd4800;
            4'd13: rate = 15'd7200;
            4'd14: rate = 15'd9600;
            4'd15: rate = 15'd19200;
            default: rate = 15'd0;
        endcase
        return rate;
    endfunction

endpackage

### hdl/sar_chan_if.sv
// Valid/ready channel interface carrying one payload struct per transaction.
// Payload type is a parameter; the block uses types from sar_pkg.
interface sar_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/sar_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hdl/sar_regs.sv
// Register stage: control/command, FIFO pointers and interrupt flags, plus the
// receive store access. Depends on sar_pkg and sar_chan_if.
module sar_regs #(
    parameter int RX_DEPTH = 16,
    parameter int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    sar_chan_if.sink          in_ch,
    input  logic              stage_ready,
    output sar_pkg::stage_t   stage,
    output logic              ram_we,
    output logic [PTR_W-1:0]  ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic              ram_re,
    output logic [PTR_W-1:0]  ram_raddr
);
    import sar_pkg::*;

    localparam int FILL_W = $clog2(RX_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    logic [7:0]        control_reg, control_next;
    logic [7:0]        command_reg, command_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              irq_en_reg, irq_en_next;
    logic              pending_reg, pending_next;

    in_item_t          req;
    out_item_t         res;
    logic              accept;
    logic              pop_hit;
    logic              push;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail_addr;
    logic [PTR_W-1:0]  head_inc;
    logic              fifo_empty;
    logic              fifo_full;

    assign req         = in_ch.payload;
    assign in_ch.ready = stage_ready;
    assign accept      = in_ch.valid && stage_ready;

    assign fifo_empty = (fill_reg == '0);
    assign fifo_full  = (fill_reg == FILL_W'(RX_DEPTH));
    assign head_inc   = (head_reg == PTR_W'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum   = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_addr  = (tail_sum >= SUM_W'(RX_DEPTH)) ?
                        PTR_W'(tail_sum - SUM_W'(RX_DEPTH)) : PTR_W'(tail_sum);

    always_comb
    begin
        control_next = control_reg;
        command_next = command_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        irq_en_next  = irq_en_reg;
        pending_next = pending_reg;
        pop_hit      = 1'b0;
        push         = 1'b0;
        res          = '0;

        unique case (req.opcode)
            OP_READ:
            begin
                unique case (req.reg_offset)
                    OFF_DATA:
                    begin
                        res.bus_driven = 1'b1;
                        if (!fifo_empty)
                        begin
                            pop_hit   = 1'b1;
                            head_next = head_inc;
                            fill_next = fill_reg - 1'b1;
                        end
                        pending_next = 1'b0;
                    end
                    OFF_STATUS:
                    begin
                        res.bus_driven = 1'b1;
                        res.read_data  = STATUS_BASE
                                       | (fifo_empty ? 8'h00 : STATUS_RXFUL)
                                       | (pending_reg ? STATUS_IRQ : 8'h00);
                    end
                    OFF_COMMAND:
                    begin
                        res.bus_driven = 1'b1;
                        res.read_data  = command_reg;
                    end
                    OFF_CONTROL:
                    begin
                        res.bus_driven = 1'b1;
                        res.read_data  = control_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_WRITE:
            begin
                unique case (req.reg_offset)
                    OFF_DATA:
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = req.write_data;
                    end
                    OFF_STATUS:
                    begin
                        control_next = '0;
                        command_next = '0;
                        head_next    = '0;
                        fill_next    = '0;
                        irq_en_next  = 1'b0;
                        pending_next = 1'b0;
                    end
                    OFF_COMMAND:
                    begin
                        command_next    = req.write_data;
                        irq_en_next     = !req.write_data[1];
                        if (req.write_data[1])
                        begin
                            pending_next = 1'b0;
                        end
                        res.line_update = 1'b1;
                    end
                    OFF_CONTROL:
                    begin
                        control_next    = req.write_data;
                        res.line_update = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_RX_BYTE:
            begin
                if (!fifo_full)
                begin
                    push      = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    if (irq_en_reg)
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            OP_RESET:
            begin
                control_next = '0;
                command_next = '0;
                head_next    = '0;
                fill_next    = '0;
                irq_en_next  = 1'b0;
                pending_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // Line format is decoded from the registers as they stand after the step.
        res.irq_level   = pending_next;
        res.baud_rate   = baud_lookup(control_next[3:0]);
        res.data_bits   = 4'd8 - {2'b00, control_next[6:5]};
        res.parity_mode = command_next[5] ? (PARITY_ODD + {1'b0, command_next[7:6]})
                                          : PARITY_NONE;
        if (!control_next[7])
        begin
            res.stop_mode = STOP_ONE;
        end
        else if (res.data_bits == 4'd5 && !command_next[5])
        begin
            res.stop_mode = STOP_ONE_HALF;
        end
        else
        begin
            res.stop_mode = STOP_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            command_reg <= '0;
            head_reg    <= '0;
            fill_reg    <= '0;
            irq_en_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            control_reg <= control_next;
            command_reg <= command_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            irq_en_reg  <= irq_en_next;
            pending_reg <= pending_next;
        end
    end

    assign stage.valid   = accept;
    assign stage.pop_hit = pop_hit;
    assign stage.item    = res;

    assign ram_we    = accept && push;
    assign ram_waddr = tail_addr;
    assign ram_wdata = req.write_data;
    assign ram_re    = accept && pop_hit;
    assign ram_raddr = head_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RX_DEPTH))
        else $error("receive fill count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store push and pop in the same transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("pop did not decrement the fill count");
endmodule

### hdl/sar_resp.sv
// Response path: pipeline stage that meets the store read data, then the
// output register. Depends on sar_pkg and sar_chan_if.
module sar_resp (
    input  logic            clk,
    input  logic            rst_n,
    input  sar_pkg::stage_t stage,
    input  logic [7:0]      ram_rdata,
    output logic            stage_ready,
    sar_chan_if.source      out_ch
);
    import sar_pkg::*;

    logic      s1_valid_reg;
    logic      s1_pop_reg;
    out_item_t s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t merged;
    logic      out_load;

    assign out_load    = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign stage_ready = !s1_valid_reg || out_load;

    always_comb
    begin
        merged = s1_item_reg;
        if (s1_pop_reg)
        begin
            merged.read_data = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage.valid)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage.valid)
        begin
            s1_pop_reg  <= stage.pop_hit;
            s1_item_reg <= stage.item;
        end
        if (out_load)
        begin
            out_item_reg <= merged;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid |-> stage_ready)
        else $error("transaction entered a full response stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stalled response stage lost its contents");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_pop_reg && !out_load |=> $stable(ram_rdata))
        else $error("store read data changed under a stalled pop");
endmodule

### hdl/serial_acia_registers_unit.sv
// Serial ACIA register block, top level. Uses sar_pkg, sar_chan_if, sar_ram,
// sar_regs and sar_resp.
//
// The block takes one transaction per clock on in_ch while out_ch keeps up:
// a bus read, a bus write, a received byte or a reset, and returns exactly
// one result transaction per input on out_ch, in order. A new transaction
// may be accepted on every cycle unless the response stage is held; a result
// passes through the response stage register into the output register, and
// one further transaction is taken while a finished result waits for
// out_ch.ready. The rate is limited only by out_ch.ready: a data read issues
// its read on the store's single registered read port in the cycle of
// acceptance; the byte is merged as the result enters the output register.
// Control, command, FIFO pointers and interrupt flags are flip-flops updated
// at acceptance, so consecutive transactions see each other's effects with
// no interlock. The receive store itself needs no clearing after reset: only
// entries written since the last reset are ever read back.
module serial_acia_registers_unit #(
    parameter int RX_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sar_chan_if.sink   in_ch,
    sar_chan_if.source out_ch
);
    import sar_pkg::*;

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    stage_t           stage;
    logic             stage_ready;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // Decode the transaction, update register state, drive the store.
    sar_regs #(
        .RX_DEPTH (RX_DEPTH),
        .PTR_W    (PTR_W)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .stage_ready (stage_ready),
        .stage       (stage),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    // Receive byte store; read data holds until the next pop.
    sar_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH),
        .AW    (PTR_W)
    ) u_rx_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Merge popped data and hold the result for out_ch.
    sar_resp u_resp (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .ram_rdata   (ram_rdata),
        .stage_ready (stage_ready),
        .out_ch      (out_ch)
    );
endmodule
